@@ rtl/hts_pkg.sv @@
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and constants of the hysteresis thermostat with backup sensor.
// ----------------------------------------------------------------------------
package hts_pkg;

	localparam int TEMP_W = 12;
	localparam int BAND_W = 10;
	localparam int CODE_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_BAND   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIRECTION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELAY_CONFIGURED  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BACKUP_CONFIGURED = 3'd5;

	// status codes
	localparam logic [CODE_W-1:0] STATUS_NORMAL       = 3'd0;
	localparam logic [CODE_W-1:0] STATUS_ON_BACKUP    = 3'd1;
	localparam logic [CODE_W-1:0] STATUS_BACKUP_ERROR = 3'd2;
	localparam logic [CODE_W-1:0] STATUS_SENSOR_ERROR = 3'd3;
	localparam logic [CODE_W-1:0] STATUS_SETUP_ERROR  = 3'd4;

	// plausible reading window, exclusive, tenths of a degree
	localparam logic signed [TEMP_W-1:0] TEMP_LOW_LIMIT  = -12'sd400;
	localparam logic signed [TEMP_W-1:0] TEMP_HIGH_LIMIT = 12'sd1200;

	localparam logic [BAND_W-1:0] BAND_RESET = 10'd10;

	typedef struct packed {
		logic signed [TEMP_W-1:0] setpoint;
		logic [BAND_W-1:0]        hysteresis_band;
		logic                     reverse_direction;
		logic                     enabled;
		logic                     relay_configured;
		logic                     backup_configured;
	} cfg_t;

	typedef struct packed {
		logic              relay_drive;
		logic              relay_written;
		logic [CODE_W-1:0] status_code;
		logic              status_valid;
	} result_t;

endpackage

@@ rtl/hts_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// hts_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module hts_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [hts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hts_pkg::CFG_DATA_W-1:0]   cfg_data,
	output hts_pkg::cfg_t                    cfg
);
	import hts_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint          <= '0;
			cfg_q.hysteresis_band   <= BAND_RESET;
			cfg_q.reverse_direction <= 1'b0;
			cfg_q.enabled           <= 1'b1;
			cfg_q.relay_configured  <= 1'b0;
			cfg_q.backup_configured <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_SETPOINT:          cfg_q.setpoint          <= $signed(cfg_data[TEMP_W-1:0]);
				REG_HYSTERESIS_BAND:   cfg_q.hysteresis_band   <= cfg_data[BAND_W-1:0];
				REG_REVERSE_DIRECTION: cfg_q.reverse_direction <= cfg_data[0];
				REG_ENABLED:           cfg_q.enabled           <= cfg_data[0];
				REG_RELAY_CONFIGURED:  cfg_q.relay_configured  <= cfg_data[0];
				REG_BACKUP_CONFIGURED: cfg_q.backup_configured <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/hts_decide.sv @@
// ----------------------------------------------------------------------------
// hts_decide
// Sensor selection, hysteresis thresholds and status for one word.
// ----------------------------------------------------------------------------
module hts_decide (
	input  hts_pkg::cfg_t                     cfg,
	input  logic signed [hts_pkg::TEMP_W-1:0] main_temp,
	input  logic signed [hts_pkg::TEMP_W-1:0] backup_temp,
	input  logic                              relay_cur,
	output hts_pkg::result_t                  res
);
	import hts_pkg::*;

	localparam int TH_W = TEMP_W + 2;

	logic                      main_ok;
	logic                      backup_ok;
	logic                      setup_err;
	logic signed [TEMP_W-1:0]  sel_temp;
	logic signed [TH_W-1:0]    sel_ext;
	logic signed [TH_W-1:0]    sp_ext;
	logic signed [TH_W-1:0]    band_ext;
	logic signed [TH_W-1:0]    hi_th;
	logic signed [TH_W-1:0]    lo_th;
	logic                      at_hi;
	logic                      at_lo;
	logic                      regulate;

	assign main_ok   = (main_temp > TEMP_LOW_LIMIT) && (main_temp < TEMP_HIGH_LIMIT)
		&& (main_temp != '0);
	assign backup_ok = (backup_temp > TEMP_LOW_LIMIT) && (backup_temp < TEMP_HIGH_LIMIT)
		&& (backup_temp != '0);
	assign setup_err = (cfg.setpoint == '0) || !cfg.relay_configured;

	assign sel_temp = main_ok ? main_temp : backup_temp;
	assign sel_ext  = {{(TH_W-TEMP_W){sel_temp[TEMP_W-1]}}, sel_temp};
	assign sp_ext   = {{(TH_W-TEMP_W){cfg.setpoint[TEMP_W-1]}}, cfg.setpoint};
	assign band_ext = $signed({{(TH_W-BAND_W){1'b0}}, cfg.hysteresis_band});
	assign hi_th    = sp_ext + band_ext;
	assign lo_th    = sp_ext - band_ext;
	assign at_hi    = sel_ext >= hi_th;
	assign at_lo    = sel_ext <= lo_th;

	assign regulate = !setup_err && cfg.enabled
		&& (main_ok || (cfg.backup_configured && backup_ok));

	always_comb begin
		res.relay_written = regulate && (at_hi || at_lo);
		res.relay_drive   = relay_cur;
		// low threshold wins when both hold
		if (regulate && at_lo) begin
			res.relay_drive = cfg.reverse_direction;
		end else if (regulate && at_hi) begin
			res.relay_drive = !cfg.reverse_direction;
		end

		res.status_code  = STATUS_NORMAL;
		res.status_valid = 1'b0;
		priority if (setup_err) begin
			res.status_code  = STATUS_SETUP_ERROR;
			res.status_valid = 1'b1;
		end else if (!cfg.enabled) begin
			res.status_code  = STATUS_NORMAL;
			res.status_valid = 1'b0;
		end else if (main_ok) begin
			res.status_code  = STATUS_NORMAL;
			res.status_valid = 1'b1;
		end else if (cfg.backup_configured) begin
			res.status_code  = backup_ok ? STATUS_ON_BACKUP : STATUS_BACKUP_ERROR;
			res.status_valid = 1'b1;
		end else begin
			res.status_code  = STATUS_SENSOR_ERROR;
			res.status_valid = 1'b1;
		end
	end

endmodule

@@ rtl/hysteresis_thermostat_backup_sensor.sv @@
// ----------------------------------------------------------------------------
// hysteresis_thermostat_backup_sensor
// On/off thermostat with hysteresis, fed by a main and a backup sensor.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with main_temp and backup_temp, one word
// per sensor tick. Output channel: out_valid/out_stall with relay_drive,
// relay_written, status_code and status_valid, exactly one word per input.
// Config: cfg_wen/cfg_index/cfg_data write port; the user must write it only while idle, the block does not enforce it.
// Timing: the accept edge loads the input register, then the result register
// loads after the threshold compares, when the output is not stalled, and
// out_valid rises with it.
// Throughput: one word per cycle while out_stall holds no result; the relay state is updated in the same
// cycle the result register loads, so back-to-back words see it at once.
// Reset: relay off, setpoint 0 (setup error until written), band 10,
// enabled, relay and backup not configured; both stages empty.
// Stall: while out_stall holds a result, the input register fills and then
// in_stall rises; nothing is dropped and the held result stays stable.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_backup_sensor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [hts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hts_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [hts_pkg::TEMP_W-1:0] main_temp,
	input  logic signed [hts_pkg::TEMP_W-1:0] backup_temp,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              relay_drive,
	output logic                              relay_written,
	output logic [hts_pkg::CODE_W-1:0]        status_code,
	output logic                              status_valid
);
	import hts_pkg::*;

	cfg_t                     cfg;
	result_t                  res;
	logic                     valid_s1;
	logic signed [TEMP_W-1:0] main_s1;
	logic signed [TEMP_W-1:0] backup_s1;
	logic                     valid_s2;
	result_t                  res_s2;
	logic                     relay_q;
	logic                     adv_s1;

	hts_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hts_decide u_decide (
		.cfg         (cfg),
		.main_temp   (main_s1),
		.backup_temp (backup_s1),
		.relay_cur   (relay_q),
		.res         (res)
	);

	assign adv_s1   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			main_s1   <= main_temp;
			backup_s1 <= backup_temp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			relay_q  <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				relay_q <= res.relay_drive;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign relay_drive   = res_s2.relay_drive;
	assign relay_written = res_s2.relay_written;
	assign status_code   = res_s2.status_code;
	assign status_valid  = res_s2.status_valid;

endmodule

@@ rtl/hts_checker.sv @@
// ----------------------------------------------------------------------------
// hts_checker
// Port-level checks of the thermostat result stream, bound to the top level.
// ----------------------------------------------------------------------------
module hts_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       relay_drive,
	input logic                       relay_written,
	input logic [hts_pkg::CODE_W-1:0] status_code,
	input logic                       status_valid
);
	import hts_pkg::*;

	logic last_relay_q;

	// relay level of the last delivered word, off after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_relay_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			last_relay_q <= relay_drive;
		end
	end

	a_relay_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !relay_written |-> relay_drive == last_relay_q)
		else $error("relay changed without a threshold write");

	a_write_needs_reading: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && relay_written |-> status_valid
			&& (status_code == STATUS_NORMAL || status_code == STATUS_ON_BACKUP))
		else $error("relay written without a usable reading");

	a_silent_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status_valid |-> status_code == STATUS_NORMAL)
		else $error("status code set while no status reported");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(relay_drive)
			&& $stable(relay_written) && $stable(status_code) && $stable(status_valid))
		else $error("stalled result word changed");

endmodule

bind hysteresis_thermostat_backup_sensor hts_checker u_hts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.relay_drive   (relay_drive),
	.relay_written (relay_written),
	.status_code   (status_code),
	.status_valid  (status_valid)
);
